/* hw/rtl/rsa_modular_exponentiation_macros.svh */
// Assertion macros shared by the modular exponentiation RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef RSA_MODULAR_EXPONENTIATION_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RME_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RME_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/rme_pkg.sv */
// Shared types and constants for the modular exponentiation block.
// No dependencies.
package rme_pkg;

  localparam int WIDTH = 31;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } rme_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rme_mul_stat_t;

endpackage

/* hw/rtl/rme_cell.sv */
// One cell of the multiplier-bit chain: loads a bit or takes its neighbour's bit.
// No package dependencies.
module rme_cell (
  input  logic clk,
  input  logic load,
  input  logic load_bit,
  input  logic shift,
  input  logic shift_in,
  output logic q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_bit;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule

/* hw/rtl/rme_mulmod.sv */
// Bit-serial modular multiplier: (a * b) mod n by double-and-add, one bit a cycle.
// Depends on rme_pkg, rme_cell and the assertion macro header.
`include "rsa_modular_exponentiation_macros.svh"
module rme_mulmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rme_pkg::WIDTH-1:0]  a,
  input  logic [rme_pkg::WIDTH-1:0]  b,
  input  logic [rme_pkg::WIDTH-1:0]  n,
  output rme_pkg::rme_mul_stat_t     stat,
  output logic [rme_pkg::WIDTH-1:0]  result
);
  import rme_pkg::*;

  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] n_q;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] acc_next;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;
  logic [WIDTH-1:0] chain;
  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;

  // Multiplier bits walk towards the top cell, which feeds the current step.
  for (genvar i = 0; i < WIDTH; i++) begin : g_cells
    rme_cell u_cell (
      .clk      (clk),
      .load     (start),
      .load_bit (b[i]),
      .shift    (busy),
      .shift_in ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
      .q        (chain[i])
    );
  end

  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    sum     = dbl_red + {1'b0, a_q};
    sum_red = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
    acc_next = chain[WIDTH-1] ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q   <= a;
      n_q   <= n;
      acc   <= '0;
      count <= CNT_W'(WIDTH-1);
    end else if (busy) begin
      acc   <= acc_next;
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

  `RME_ASSERT_NEXT(a_start_busy, start, busy)
  `RME_ASSERT_SAME(a_done_idle, done, !busy)
  `RME_ASSERT_SAME(a_result_reduced, done && (n_q > WIDTH'(1)), acc < n_q)

endmodule

/* hw/rtl/rsa_modular_exponentiation.sv */
// Top level of the modular exponentiation block: control and registers.
// Depends on rme_pkg, rme_mulmod and the assertion macro header.
//
// Usage: configuration beats on the cfg channel (cfg_index 0 = modulus,
// 1 = exponent, other indexes ignored) are always accepted and should only
// be sent while the block is idle. Each beat on the input channel carries one
// base_value; exactly one power_result beat follows, equal to base_value
// raised to the exponent, reduced modulo the modulus. A modulus of zero or
// one gives zero. Items are processed one at a time.
// Each modular product runs through the bit-serial multiplier as a start,
// 31 bit steps and a done pulse. An item takes one product to reduce the
// base, then 31 squarings and one multiply per set exponent bit, then the
// finish state; out_valid rises in the same cycle as in_ready, when the next
// input beat can be taken. A trivial modulus skips the multiplier and goes
// straight from its input beat to the finish state.
// The result sits in an output register, so a new input beat is taken while
// a finished result still waits. If the receiver stalls and the next result
// is ready too, the block holds that result and takes no input until the
// output register frees. Reset clears the control state, drops out_valid and
// loads modulus 1 and exponent 1.
`include "rsa_modular_exponentiation_macros.svh"
module rsa_modular_exponentiation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rme_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rme_pkg::WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rme_pkg::WIDTH-1:0]  base_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rme_pkg::WIDTH-1:0]  power_result
);
  import rme_pkg::*;

  rme_state_t       state;
  rme_state_t       state_next;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] n_q;
  logic [WIDTH-1:0] e_q;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] acc;
  logic [CNT_W-1:0] bit_idx;
  logic             launched;
  logic             mul_start;
  logic             computing;
  logic             out_free;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] mul_b;
  logic [WIDTH-1:0] mul_res;
  rme_mul_stat_t    mul_stat;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= WIDTH'(1);
      exponent <= WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data;
        REG_EXPONENT: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (modulus <= WIDTH'(1)) ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_stat.done) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (mul_stat.done) begin
          if (e_q[bit_idx]) begin
            state_next = ST_MULT;
          end else if (bit_idx == '0) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_MULT: begin
        if (mul_stat.done) state_next = (bit_idx == '0) ? ST_FINISH : ST_SQUARE;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    computing = (state == ST_REDUCE) || (state == ST_SQUARE) || (state == ST_MULT);
    mul_start = computing && !launched;
    // Reduction of the base runs as 1 * base, which is restoring division.
    unique case (state)
      ST_REDUCE: begin
        mul_a = WIDTH'(1);
        mul_b = base_r;
      end
      ST_MULT: begin
        mul_a = acc;
        mul_b = base_r;
      end
      default: begin
        mul_a = acc;
        mul_b = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_start) begin
        launched <= 1'b1;
      end else if (mul_stat.done) begin
        launched <= 1'b0;
      end
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      n_q     <= modulus;
      e_q     <= exponent;
      base_r  <= base_value;
      acc     <= '0;
      bit_idx <= CNT_W'(WIDTH-1);
    end else if (mul_stat.done) begin
      unique case (state)
        ST_REDUCE: begin
          base_r <= mul_res;
          acc    <= WIDTH'(1);
        end
        ST_SQUARE: begin
          acc <= mul_res;
          if (!e_q[bit_idx] && (bit_idx != '0)) bit_idx <= bit_idx - 1'b1;
        end
        ST_MULT: begin
          acc <= mul_res;
          if (bit_idx != '0) bit_idx <= bit_idx - 1'b1;
        end
        default: ;
      endcase
    end
    if ((state == ST_FINISH) && out_free) begin
      power_result <= acc;
    end
  end

  rme_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .n      (n_q),
    .stat   (mul_stat),
    .result (mul_res)
  );

  `RME_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state != ST_IDLE)
  `RME_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(power_result))
  `RME_ASSERT_SAME(a_start_in_compute, mul_start, computing && !mul_stat.busy)

endmodule

/* dv/tb_rsa_modular_exponentiation.sv */
// Self-checking testbench for the modular exponentiation block.
// Depends on rme_pkg and the rsa_modular_exponentiation RTL only.
`timescale 1ns / 1ps
module tb_rsa_modular_exponentiation;
  import rme_pkg::*;

  typedef logic [WIDTH-1:0] word_t;

  localparam word_t WORD_MAX = {WIDTH{1'b1}};
  // Indexes past the register list; writes to them must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(3);
  // ITEM_LATENCY bounds the worst unstalled item; the stall limit allows generous headroom.
  localparam int ITEM_LATENCY = 2100;
  localparam int STALL_LIMIT  = 10 * ITEM_LATENCY;
  localparam int RANDOM_ITEMS = 270;
  localparam int QUIET_TAIL   = 40;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  word_t      cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  word_t      base_value = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  word_t      power_result;

  rsa_modular_exponentiation u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .base_value   (base_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .power_result (power_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Our own copy of the two registers, updated on each accepted config beat to either of them.
  word_t modulus_reg  = word_t'(1);
  word_t exponent_reg = word_t'(1);

  // Expected powers, oldest first; one entry per accepted base beat.
  word_t powers_due[$];
  int    err_cnt = 0;
  bit    quiet = 1'b0;     // when set, neither side inserts idle cycles
  int    stuck_cycles = 0;

  // Left-to-right square-and-multiply. Every operand stays below the modulus,
  // so the 62-bit products fit comfortably in 64 bits.
  function automatic word_t mod_power(word_t b, word_t e, word_t m);
    longint unsigned n;
    longint unsigned acc;
    longint unsigned bb;
    n = m;
    if (n <= 1) return '0;
    bb  = longint'(b) % n;
    acc = 1;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % n;
      if (e[i]) acc = (acc * bb) % n;
    end
    return word_t'(acc);
  endfunction

  // Monitor and checker: everything is sampled at the rising edge.
  always @(posedge clk) begin
    word_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODULUS) modulus_reg <= cfg_data;
        else if (cfg_index == REG_EXPONENT) exponent_reg <= cfg_data;
      end
      if (in_valid && in_ready)
        powers_due.push_back(mod_power(base_value, exponent_reg, modulus_reg));
      if (out_valid && out_ready) begin
        if (powers_due.size() == 0) begin
          $error("power_result beat with nothing expected: actual %0d", power_result);
          err_cnt++;
        end else begin
          want = powers_due.pop_front();
          if (power_result !== want) begin
            $error("power_result mismatch: expected %0d, actual %0d", want, power_result);
            err_cnt++;
          end
        end
      end
      // Watchdog: any beat on any channel counts as progress.
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        stuck_cycles <= 0;
      else if (stuck_cycles + 1 >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else
        stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: at random, holds ready low for a burst, else keeps it high.
  always @(negedge clk) begin
    int hold;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold = $urandom_range(1, 6);
      out_ready <= 1'b0;
      repeat (hold - 1) @(negedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One configuration beat, driven at the falling edge.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input word_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected power has come back, then a short settle.
  task automatic drain();
    while (powers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Reprograms both registers, but only once the block has gone idle.
  task automatic set_key(input word_t m, input word_t e);
    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_MODULUS, m);
    write_reg(REG_EXPONENT, e);
  endtask

  // Sends one base beat; valid stays high into the next beat unless a gap
  // is chosen, in which case it drops for a random burst first.
  task automatic send_base(input word_t b);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    base_value <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Directed rows. A row with a known answer also checks it directly, on top
  // of the predictor, so a wrong predictor cannot hide an obvious fault.
  typedef struct {
    word_t m;
    word_t e;
    word_t b;
    bit    known;
    word_t ans;
  } vec_t;

  vec_t vecs[$];

  task automatic add_vec(word_t m, word_t e, word_t b, bit known, word_t ans);
    vec_t v;
    v.m = m; v.e = e; v.b = b; v.known = known; v.ans = ans;
    vecs.push_back(v);
  endtask

  initial begin
    word_t m;
    word_t e;
    word_t cur_m;
    word_t cur_e;
    int    phases;

    // Reset state is modulus one, exponent one: every answer is zero.
    add_vec(1, 1, 0, 1, 0);
    add_vec(1, 1, WORD_MAX, 1, 0);
    // Modulus zero behaves like modulus one.
    add_vec(0, 5, 12345, 1, 0);
    // Exponent zero gives one for any real modulus, including base zero.
    add_vec(97, 0, 0, 1, 1);
    add_vec(WORD_MAX, 0, WORD_MAX, 1, 1);
    // Base not below the modulus is reduced first.
    add_vec(97, 1, 97, 1, 0);
    add_vec(97, 1, 200, 1, 6);
    add_vec(97, 2, 98, 1, 1);
    add_vec(2, WORD_MAX, 3, 1, 1);
    // Small textbook key: 65^17 mod 3233 = 2790, and back again.
    add_vec(3233, 17, 65, 1, 2790);
    add_vec(3233, 2753, 2790, 1, 65);
    // Largest moduli, the largest exponent and 65537, extreme and other bases.
    add_vec(WORD_MAX, WORD_MAX, WORD_MAX - 1, 1, WORD_MAX - 1);
    add_vec(WORD_MAX, WORD_MAX, 2, 0, 0);
    add_vec(WORD_MAX, 65537, WORD_MAX, 1, 0);
    add_vec(WORD_MAX - 1, 65537, 123456789, 0, 0);
    add_vec(WORD_MAX - 1, WORD_MAX, 1, 1, 1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Writes past the register list must leave the key untouched.
    write_reg(REG_SPARE_LO, 31'h5555_5555);
    write_reg(REG_SPARE_HI, 31'h2AAA_AAAA);

    cur_m = 1;
    cur_e = 1;
    foreach (vecs[i]) begin
      if (vecs[i].m != cur_m || vecs[i].e != cur_e) begin
        set_key(vecs[i].m, vecs[i].e);
        cur_m = vecs[i].m;
        cur_e = vecs[i].e;
      end
      if (vecs[i].known && mod_power(vecs[i].b, cur_e, cur_m) != vecs[i].ans) begin
        $error("power_result table: expected %0d, predicted %0d",
               vecs[i].ans, mod_power(vecs[i].b, cur_e, cur_m));
        err_cnt++;
      end
      send_base(vecs[i].b);
    end

    // Random phases: each picks a key, then a run of random bases.
    phases = 10;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0: m = word_t'($urandom_range(0, 3));
        1: m = WORD_MAX;
        2: m = word_t'($urandom_range(2, 1000));
        default: m = word_t'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: e = word_t'($urandom_range(0, 3));
        1: e = WORD_MAX;
        2: e = word_t'(65537);
        default: e = word_t'($urandom);
      endcase
      set_key(m, e);
      for (int k = 0; k < RANDOM_ITEMS / phases; k++) begin
        if (p == phases - 1 && k >= RANDOM_ITEMS / phases - QUIET_TAIL) quiet = 1'b1;
        if (p == phases - 1) quiet = 1'b1;
        send_base($urandom_range(0, 7) == 0 ? WORD_MAX : word_t'($urandom));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    repeat (ITEM_LATENCY / 20) @(posedge clk);
    if (powers_due.size() != 0) begin
      $error("power_result: %0d expected beats never arrived", powers_due.size());
      err_cnt++;
    end

    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
